// ----- design/tipu_pkg.sv -----
// ----------------------------------------------------------------------------
// tipu_pkg
// Shared types, constants and helpers of the tensor index pack/unpack core.
// ----------------------------------------------------------------------------
package tipu_pkg;

    localparam int NUM_DIMS    = 6;
    localparam int LIN_W       = 32;
    localparam int IDX_W       = 16;
    localparam int STR_W       = LIN_W + 1;        // saturates at 2^LIN_W
    localparam int SUM_W       = LIN_W + 4;
    localparam int PREP_STAGES = 8;
    localparam int DIV_BITS    = 4;                // quotient bits per stage
    localparam int DIV_PER_DIM = LIN_W / DIV_BITS;
    localparam int DIV_STAGES  = DIV_PER_DIM * NUM_DIMS;
    localparam logic [STR_W-1:0] SAT_LIM = {1'b1, {LIN_W{1'b0}}};

    typedef enum logic [2:0] {
        REG_RANK = 3'd0,
        REG_DIM0 = 3'd1,
        REG_DIM1 = 3'd2,
        REG_DIM2 = 3'd3,
        REG_DIM3 = 3'd4,
        REG_DIM4 = 3'd5,
        REG_DIM5 = 3'd6
    } t_reg_idx;

    typedef enum logic {
        MODE_UNPACK = 1'b0,
        MODE_PACK   = 1'b1
    } t_mode;

    typedef struct packed {
        logic [NUM_DIMS-1:0][IDX_W-1:0] dim;   // size, 1 for unused dims
        logic [NUM_DIMS-1:0]            used;
    } t_cfg;

    typedef struct packed {
        t_mode                          mode;
        logic                           err;
        logic [LIN_W-1:0]               lin;
        logic [STR_W-1:0]               prod;  // tensor size, saturated
        logic [IDX_W-1:0]               rem;
        logic [LIN_W-1:0]               quo;
        logic [NUM_DIMS-1:0][IDX_W-1:0] idx;
        logic [NUM_DIMS-1:0][IDX_W-1:0] ixo;
        logic [NUM_DIMS-1:0][STR_W-1:0] strd;  // strides, later terms
    } t_item;

    // a * b clipped to 2^LIN_W; zero stays zero
    function automatic logic [STR_W-1:0] sat_mul(input logic [STR_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
        logic [STR_W+IDX_W-1:0] p;
        p = (STR_W+IDX_W)'(a) * (STR_W+IDX_W)'(b);
        if (p > (STR_W+IDX_W)'(SAT_LIM)) begin
            return SAT_LIM;
        end
        return p[STR_W-1:0];
    endfunction

endpackage

// ----- design/tipu_if.sv -----
// ----------------------------------------------------------------------------
// tipu_in_if / tipu_out_if
// Valid/ready word channels of the tensor index pack/unpack core.
// ----------------------------------------------------------------------------
interface tipu_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] linear_index;
    logic [15:0] index_0;
    logic [15:0] index_1;
    logic [15:0] index_2;
    logic [15:0] index_3;
    logic [15:0] index_4;
    logic [15:0] index_5;

    modport source (output valid, mode, linear_index, index_0, index_1, index_2,
                    index_3, index_4, index_5, input ready);
    modport sink   (input valid, mode, linear_index, index_0, index_1, index_2,
                    index_3, index_4, index_5, output ready);
endinterface

interface tipu_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] linear_result;
    logic [15:0] index_out_0;
    logic [15:0] index_out_1;
    logic [15:0] index_out_2;
    logic [15:0] index_out_3;
    logic [15:0] index_out_4;
    logic [15:0] index_out_5;
    logic        error;

    modport source (output valid, linear_result, index_out_0, index_out_1,
                    index_out_2, index_out_3, index_out_4, index_out_5, error,
                    input ready);
    modport sink   (input valid, linear_result, index_out_0, index_out_1,
                    index_out_2, index_out_3, index_out_4, index_out_5, error,
                    output ready);
endinterface

// ----- design/tensor_index_pack_unpack_core.sv -----
// ----------------------------------------------------------------------------
// tensor_index_pack_unpack_core
// Row-major offset <-> per-dimension index conversion, fully pipelined.
//
//   port      dir  kind           carries
//   i_src     in   valid/ready    mode, linear_index, index_0..5
//   o_dst     out  valid/ready    linear_result, index_out_0..5, error
//   p*        in   APB            rank, dim_size_0..5
//
// One word per cycle sustained while o_dst accepts; 8 prep stages, 48 divider
// stages at 4 quotient bits each, one output register.
// Reset (synchronous, i_rst_n low) empties every stage and sets rank = 1 and
// all sizes = 1. Each stage holds its word while its successor is full and
// stalled; empty stages still fill, so a held output does not stop intake
// until the whole pipe is full.
// ----------------------------------------------------------------------------
module tensor_index_pack_unpack_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tipu_in_if.sink     i_src,
    tipu_out_if.source  o_dst,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    tipu_pkg::t_cfg  w_cfg;
    tipu_pkg::t_item w_in;
    tipu_pkg::t_item w_pd;
    tipu_pkg::t_item w_dd;
    logic            w_pv, w_pr, w_dv, w_dr, w_adv;
    logic            r_out_vld;
    tipu_pkg::t_item r_out;
    tipu_pkg::t_item n_out;

    tipu_cfg u_cfg (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_cfg(w_cfg)
    );

    always_comb begin
        w_in      = '0;
        w_in.mode = tipu_pkg::t_mode'(i_src.mode);
        w_in.quo  = i_src.linear_index;
        w_in.idx  = {i_src.index_5, i_src.index_4, i_src.index_3,
                     i_src.index_2, i_src.index_1, i_src.index_0};
        for (int k = 0; k < tipu_pkg::NUM_DIMS; k++) begin
            if (!w_cfg.used[k]) w_in.idx[k] = '0;
        end
        w_in.strd[tipu_pkg::NUM_DIMS-1] = tipu_pkg::STR_W'(1);
    end

    tipu_prep u_prep (
        .i_clk, .i_rst_n, .i_cfg(w_cfg),
        .i_valid(i_src.valid), .o_ready(i_src.ready), .i_dat(w_in),
        .o_valid(w_pv), .i_ready(w_pr), .o_dat(w_pd)
    );

    tipu_div u_div (
        .i_clk, .i_rst_n, .i_cfg(w_cfg),
        .i_valid(w_pv), .o_ready(w_pr), .i_dat(w_pd),
        .o_valid(w_dv), .i_ready(w_dr), .o_dat(w_dd)
    );

    assign w_adv = !r_out_vld || o_dst.ready;
    assign w_dr  = w_adv;

    // errors clear every field but the error flag; each mode shows only its own fields
    always_comb begin
        n_out     = '0;
        n_out.err = w_dd.err;
        if (!w_dd.err) begin
            if (w_dd.mode == tipu_pkg::MODE_PACK) begin
                n_out.lin = w_dd.lin;
            end else begin
                n_out.ixo = w_dd.ixo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_dv;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_dst.valid         = r_out_vld;
    assign o_dst.linear_result = r_out.lin;
    assign o_dst.index_out_0   = r_out.ixo[0];
    assign o_dst.index_out_1   = r_out.ixo[1];
    assign o_dst.index_out_2   = r_out.ixo[2];
    assign o_dst.index_out_3   = r_out.ixo[3];
    assign o_dst.index_out_4   = r_out.ixo[4];
    assign o_dst.index_out_5   = r_out.ixo[5];
    assign o_dst.error         = r_out.err;
endmodule

// ----- design/tipu_cfg.sv -----
// ----------------------------------------------------------------------------
// tipu_cfg
// APB register file: rank and dimension sizes, effective shape for the datapath.
// ----------------------------------------------------------------------------
module tipu_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output tipu_pkg::t_cfg o_cfg
);
    logic [2:0]  r_rank;
    logic [tipu_pkg::NUM_DIMS-1:0][tipu_pkg::IDX_W-1:0] r_dim;
    logic [2:0]  w_rank_eff;
    logic        w_wr;
    tipu_pkg::t_reg_idx w_sel;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_sel  = tipu_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank <= 3'd1;
            for (int k = 0; k < tipu_pkg::NUM_DIMS; k++) r_dim[k] <= 16'd1;
        end else if (w_wr) begin
            case (w_sel)
                tipu_pkg::REG_RANK: r_rank   <= pwdata[2:0];
                tipu_pkg::REG_DIM0: r_dim[0] <= pwdata[15:0];
                tipu_pkg::REG_DIM1: r_dim[1] <= pwdata[15:0];
                tipu_pkg::REG_DIM2: r_dim[2] <= pwdata[15:0];
                tipu_pkg::REG_DIM3: r_dim[3] <= pwdata[15:0];
                tipu_pkg::REG_DIM4: r_dim[4] <= pwdata[15:0];
                tipu_pkg::REG_DIM5: r_dim[5] <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_sel)
            tipu_pkg::REG_RANK: prdata = {29'd0, r_rank};
            tipu_pkg::REG_DIM0: prdata = {16'd0, r_dim[0]};
            tipu_pkg::REG_DIM1: prdata = {16'd0, r_dim[1]};
            tipu_pkg::REG_DIM2: prdata = {16'd0, r_dim[2]};
            tipu_pkg::REG_DIM3: prdata = {16'd0, r_dim[3]};
            tipu_pkg::REG_DIM4: prdata = {16'd0, r_dim[4]};
            tipu_pkg::REG_DIM5: prdata = {16'd0, r_dim[5]};
            default:            prdata = 32'd0;
        endcase
    end

    // rank 0 acts as 1, anything above 6 as 6
    always_comb begin
        if (r_rank == 3'd0) begin
            w_rank_eff = 3'd1;
        end else if (r_rank > 3'(tipu_pkg::NUM_DIMS)) begin
            w_rank_eff = 3'(tipu_pkg::NUM_DIMS);
        end else begin
            w_rank_eff = r_rank;
        end
        for (int k = 0; k < tipu_pkg::NUM_DIMS; k++) begin
            o_cfg.used[k] = (3'(k) < w_rank_eff);
            o_cfg.dim[k]  = o_cfg.used[k] ? r_dim[k] : 16'd1;
        end
    end
endmodule

// ----- design/tipu_prep.sv -----
// ----------------------------------------------------------------------------
// tipu_prep
// Stride chain, pack products, packed sum and range checks, one step a stage.
// ----------------------------------------------------------------------------
module tipu_prep (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tipu_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  tipu_pkg::t_item i_dat,
    output logic            o_valid,
    input  logic            i_ready,
    output tipu_pkg::t_item o_dat
);
    localparam int N = tipu_pkg::PREP_STAGES;

    logic            r_vld [N];
    tipu_pkg::t_item r_dat [N];
    tipu_pkg::t_item n_dat [N];
    logic [N:0]      w_adv;

    assign w_adv[N] = i_ready;
    assign o_ready  = w_adv[0];
    assign o_valid  = r_vld[N-1];
    assign o_dat    = r_dat[N-1];

    // stage 0 registers the word, 1..5 build strides inner to outer,
    // 6 forms tensor size and index * stride, 7 sums and checks
    always_comb begin
        logic [tipu_pkg::SUM_W-1:0] sum;
        logic                       bad;
        n_dat[0] = i_dat;
        for (int s = 1; s < N; s++) n_dat[s] = r_dat[s-1];
        for (int s = 1; s <= 5; s++) begin
            n_dat[s].strd[5-s] = tipu_pkg::sat_mul(r_dat[s-1].strd[6-s],
                                                   i_cfg.dim[6-s]);
        end
        n_dat[6].prod = tipu_pkg::sat_mul(r_dat[5].strd[0], i_cfg.dim[0]);
        for (int k = 0; k < tipu_pkg::NUM_DIMS; k++) begin
            n_dat[6].strd[k] = tipu_pkg::sat_mul(r_dat[5].strd[k], r_dat[5].idx[k]);
        end
        sum = '0;
        bad = 1'b0;
        for (int k = 0; k < tipu_pkg::NUM_DIMS; k++) begin
            sum = sum + tipu_pkg::SUM_W'(r_dat[6].strd[k]);
            bad = bad | (r_dat[6].idx[k] >= i_cfg.dim[k]);
        end
        n_dat[7].lin = sum[tipu_pkg::LIN_W-1:0];
        if (r_dat[6].mode == tipu_pkg::MODE_PACK) begin
            n_dat[7].err = bad | (|sum[tipu_pkg::SUM_W-1:tipu_pkg::LIN_W]);
        end else begin
            n_dat[7].err = ({1'b0, r_dat[6].quo} >= r_dat[6].prod);
        end
    end

    for (genvar s = 0; s < N; s++) begin : g_st
        assign w_adv[s] = !r_vld[s] || w_adv[s+1];
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (w_adv[s]) begin
                r_vld[s] <= (s == 0) ? i_valid : r_vld[(s == 0) ? 0 : s-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv[s]) begin
                r_dat[s] <= n_dat[s];
            end
        end
    end
endmodule

// ----- design/tipu_div.sv -----
// ----------------------------------------------------------------------------
// tipu_div
// Pipelined restoring divider: offset split by each dimension, innermost first.
// ----------------------------------------------------------------------------
module tipu_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tipu_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  tipu_pkg::t_item i_dat,
    output logic            o_valid,
    input  logic            i_ready,
    output tipu_pkg::t_item o_dat
);
    localparam int N = tipu_pkg::DIV_STAGES;

    logic            r_vld [N];
    tipu_pkg::t_item r_dat [N];
    tipu_pkg::t_item w_prv [N];
    logic            w_pvl [N];
    logic [N:0]      w_adv;

    assign w_adv[N] = i_ready;
    assign o_ready  = w_adv[0];
    assign o_valid  = r_vld[N-1];
    assign o_dat    = r_dat[N-1];

    for (genvar j = 0; j < N; j++) begin : g_st
        localparam int K     = tipu_pkg::NUM_DIMS - 1 - j / tipu_pkg::DIV_PER_DIM;
        localparam int PHASE = j % tipu_pkg::DIV_PER_DIM;
        tipu_pkg::t_item n_dat;

        if (j == 0) begin : g_first
            assign w_prv[j] = i_dat;
            assign w_pvl[j] = i_valid;
        end else begin : g_next
            assign w_prv[j] = r_dat[j-1];
            assign w_pvl[j] = r_vld[j-1];
        end

        assign w_adv[j] = !r_vld[j] || w_adv[j+1];

        // remainder restarts at zero per dimension; quotient carries over
        always_comb begin
            logic [tipu_pkg::IDX_W-1:0] rm;
            logic [tipu_pkg::LIN_W-1:0] qq;
            logic [tipu_pkg::IDX_W:0]   t;
            n_dat = w_prv[j];
            rm = (PHASE == 0) ? '0 : w_prv[j].rem;
            qq = w_prv[j].quo;
            for (int b = 0; b < tipu_pkg::DIV_BITS; b++) begin
                t  = {rm, qq[tipu_pkg::LIN_W-1]};
                qq = {qq[tipu_pkg::LIN_W-2:0], 1'b0};
                if (t >= {1'b0, i_cfg.dim[K]}) begin
                    rm    = tipu_pkg::IDX_W'(t - {1'b0, i_cfg.dim[K]});
                    qq[0] = 1'b1;
                end else begin
                    rm = t[tipu_pkg::IDX_W-1:0];
                end
            end
            n_dat.rem = rm;
            n_dat.quo = qq;
            if (PHASE == tipu_pkg::DIV_PER_DIM - 1) begin
                n_dat.ixo[K] = rm;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (w_adv[j]) begin
                r_vld[j] <= w_pvl[j];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv[j]) begin
                r_dat[j] <= n_dat;
            end
        end
    end
endmodule

// ----- tb/tipu_tb_if.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tipu_tb_if
// The block's word channels are defined with the design (tipu_in_if and
// tipu_out_if). This file only holds the result type of the bench.
// ----------------------------------------------------------------------------
package tipu_tb_pkg;

    typedef struct packed {
        logic [31:0]      lin;
        logic [5:0][15:0] ixo;
        logic             err;
    } t_result;

endpackage

// ----- tb/tensor_index_pack_unpack_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tensor_index_pack_unpack_core_tb
// Drives pack and unpack words through the core under several tensor shapes,
// predicts each result from the configured rank and sizes and checks the
// output words in order, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tensor_index_pack_unpack_core_tb;

    class index_scoreboard;
        tipu_tb_pkg::t_result pending[$];
        int      fails;
        int      rank_reg;
        int      dims[6];

        task report_err(string msg);
            if (fails < 50) $display("MISMATCH t=%0t: %s", $time, msg);
            fails++;
        endtask

        function void note_word(logic mode, logic [31:0] lin, logic [5:0][15:0] ix);
            tipu_tb_pkg::t_result r;
            longint unsigned sz, acc, strd, cur, d, lim;
            int rk;
            bit big;
            r = '0;
            lim = 64'hFFFF_FFFF;
            rk = (rank_reg == 0) ? 1 : (rank_reg > 6 ? 6 : rank_reg);
            if (mode == tipu_pkg::MODE_UNPACK) begin
                sz = 1; big = 0;
                for (int k = 0; k < rk; k++) begin
                    d = dims[k];
                    if (d == 0) r.err = 1;
                    else if (!big) begin
                        if (sz > lim / d) big = 1; else sz *= d;
                    end
                end
                if (!r.err && !big && lin >= sz) r.err = 1;
                if (!r.err) begin
                    cur = lin;
                    for (int k = rk - 1; k >= 0; k--) begin
                        r.ixo[k] = 16'(cur % dims[k]);
                        cur = cur / dims[k];
                    end
                end
            end else begin
                acc = 0; strd = 1; big = 0;
                for (int k = rk - 1; k >= 0 && !r.err; k--) begin
                    d = dims[k];
                    if (ix[k] >= d) r.err = 1;
                    else begin
                        if (ix[k] != 0) begin
                            if (big || strd > (lim - acc) / ix[k]) r.err = 1;
                            else acc += ix[k] * strd;
                        end
                        if (!big) begin
                            if (strd > lim / d) big = 1; else strd *= d;
                        end
                    end
                end
                if (!r.err) r.lin = acc[31:0];
            end
            pending.push_back(r);
        endfunction

        task check_word(tipu_tb_pkg::t_result got);
            tipu_tb_pkg::t_result exp_r;
            if (pending.size() == 0) begin
                report_err("result word with nothing expected");
                return;
            end
            exp_r = pending.pop_front();
            if (got.err !== exp_r.err) report_err($sformatf("error %b exp %b", got.err, exp_r.err));
            if (got.lin !== exp_r.lin)
                report_err($sformatf("linear_result %h exp %h", got.lin, exp_r.lin));
            for (int k = 0; k < 6; k++)
                if (got.ixo[k] !== exp_r.ixo[k])
                    report_err($sformatf("index_out_%0d %h exp %h", k, got.ixo[k], exp_r.ixo[k]));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite, pready;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;
    tipu_in_if   src_if();
    tipu_out_if  dst_if();

    index_scoreboard sb;
    int  hold_cycles;

    tensor_index_pack_unpack_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_src(src_if.sink), .o_dst(dst_if.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic reg_write(tipu_pkg::t_reg_idx ri, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(ri) << 2;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (ri == tipu_pkg::REG_RANK) sb.rank_reg = val[2:0];
        else sb.dims[int'(ri) - 1] = val[15:0];
        @(posedge i_clk);
    endtask

    task automatic set_shape(int rk, int d0, int d1, int d2, int d3, int d4, int d5);
        reg_write(tipu_pkg::REG_RANK, rk);
        reg_write(tipu_pkg::REG_DIM0, d0);
        reg_write(tipu_pkg::REG_DIM1, d1);
        reg_write(tipu_pkg::REG_DIM2, d2);
        reg_write(tipu_pkg::REG_DIM3, d3);
        reg_write(tipu_pkg::REG_DIM4, d4);
        reg_write(tipu_pkg::REG_DIM5, d5);
    endtask

    task automatic send_word(logic mode, logic [31:0] lin, logic [5:0][15:0] ix, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            src_if.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        src_if.valid        <= 1'b1;
        src_if.mode         <= mode;
        src_if.linear_index <= lin;
        src_if.index_0 <= ix[0]; src_if.index_1 <= ix[1]; src_if.index_2 <= ix[2];
        src_if.index_3 <= ix[3]; src_if.index_4 <= ix[4]; src_if.index_5 <= ix[5];
        do @(posedge i_clk); while (!src_if.ready);
        sb.note_word(mode, lin, ix);
    endtask

    task automatic drain();
        src_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (70) @(posedge i_clk);
    endtask

    // random word: mostly in range for the current shape, some out of range
    task automatic send_random(int rk);
        logic [5:0][15:0] ix;
        logic [31:0] lin;
        longint unsigned sz;
        logic mode;
        sz = 1;
        for (int k = 0; k < rk; k++) sz *= (sb.dims[k] == 0 ? 1 : sb.dims[k]);
        for (int k = 0; k < 6; k++) begin
            if (k < rk && sb.dims[k] != 0 && $urandom_range(0, 9) != 0)
                ix[k] = 16'($urandom_range(0, sb.dims[k] - 1));
            else ix[k] = 16'($urandom);
        end
        if ($urandom_range(0, 9) == 0 || sz > 64'hFFFF_FFFF) lin = $urandom;
        else lin = 32'($urandom_range(0, 32'(sz - 1)));
        mode = 1'($urandom_range(0, 1));
        send_word(mode, lin, ix, 1'b1);
    endtask

    // sink side: random stalls, one long hold-off on request
    initial begin
        tipu_tb_pkg::t_result got;
        int g;
        dst_if.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_cycles > 0) begin
                dst_if.ready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end else if ($urandom_range(0, 3) == 0) begin
                g = gap_len();
                if (g > 0) begin
                    dst_if.ready <= 1'b0;
                    repeat (g) @(posedge i_clk);
                end
            end
            dst_if.ready <= 1'b1;
            @(posedge i_clk);
            if (dst_if.valid && dst_if.ready) begin
                got.lin = dst_if.linear_result;
                got.ixo = {dst_if.index_out_5, dst_if.index_out_4, dst_if.index_out_3,
                           dst_if.index_out_2, dst_if.index_out_1, dst_if.index_out_0};
                got.err = dst_if.error;
                sb.check_word(got);
            end
        end
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int rk;
        sb = new();
        sb.rank_reg = 1;
        foreach (sb.dims[k]) sb.dims[k] = 1;
        hold_cycles = 0;
        i_rst_n = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        src_if.valid = 0; src_if.mode = 0; src_if.linear_index = 0;
        src_if.index_0 = 0; src_if.index_1 = 0; src_if.index_2 = 0;
        src_if.index_3 = 0; src_if.index_4 = 0; src_if.index_5 = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset shape: one element
        send_word(tipu_pkg::MODE_UNPACK, 0, '0, 0);
        send_word(tipu_pkg::MODE_UNPACK, 1, '0, 0);
        send_word(tipu_pkg::MODE_PACK, 0,
                  {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0}, 0);
        send_word(tipu_pkg::MODE_PACK, 0, {80'h0, 16'h1}, 0);
        drain();

        // full rank, largest sizes: offsets overflow width
        set_shape(6, 65535, 65535, 65535, 65535, 65535, 65535);
        send_word(tipu_pkg::MODE_UNPACK, 32'hFFFF_FFFF, '0, 0);
        send_word(tipu_pkg::MODE_UNPACK, 0, '0, 0);
        send_word(tipu_pkg::MODE_PACK, 0, {6{16'hFFFE}}, 0);
        send_word(tipu_pkg::MODE_PACK, 0,
                  {16'h0, 16'h0, 16'h0, 16'h0, 16'hFFFE, 16'hFFFE}, 0);
        send_word(tipu_pkg::MODE_PACK, 0, {16'h0, 16'h0, 16'h0, 16'h0, 16'h1, 16'h0}, 0);
        send_word(tipu_pkg::MODE_PACK, 0,
                  {16'hFFFE, 16'hFFFE, 16'h0, 16'h0, 16'h0, 16'h0}, 0);
        drain();

        // rank field 0 and 7, zero size
        set_shape(0, 7, 0, 3, 3, 3, 3);
        send_word(tipu_pkg::MODE_UNPACK, 6, '0, 0);
        send_word(tipu_pkg::MODE_UNPACK, 7, '0, 0);
        send_word(tipu_pkg::MODE_PACK, 0, {80'h0, 16'h6}, 0);
        drain();
        reg_write(tipu_pkg::REG_RANK, 7);
        send_word(tipu_pkg::MODE_UNPACK, 5, '0, 0);
        send_word(tipu_pkg::MODE_PACK, 0, {16'h2, 16'h2, 16'h2, 16'h2, 16'h0, 16'h6}, 0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            rk = $urandom_range(1, 7);
            if (ph == 5) set_shape(rk, 65535, 2, 65535, 1, 3, 65535);
            else set_shape(rk, $urandom_range(1, 40), $urandom_range(1, 300),
                           $urandom_range(1, 9), $urandom_range(1, 65535),
                           $urandom_range(1, 17), $urandom_range(1, 5));
            rk = (rk > 6) ? 6 : rk;
            // long enough that the whole pipe fills and intake stalls
            if (ph == 1) hold_cycles = 600;
            for (int n = 0; n < 100; n++) send_random(rk);
            drain();
        end

        if (sb.fails == 0 && sb.pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
